/* hdl/bba_pkg.sv */
// Shared constants, codes and control types of the bitmap block allocator.
`default_nettype none
package bba_pkg;

  // Bitmap geometry
  localparam int MAX_BLOCKS = 4096;
  localparam int WORD_BITS  = 64;
  localparam int NUM_WORDS  = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int BLK_W      = $clog2(MAX_BLOCKS);
  localparam int TOTAL_W    = BLK_W + 1;
  localparam int BIT_W      = $clog2(WORD_BITS);
  localparam int WADDR_W    = $clog2(NUM_WORDS);
  localparam int ST_W       = 2;

  // Register reset value
  localparam logic [TOTAL_W-1:0] TOTAL_RESET = TOTAL_W'(MAX_BLOCKS);

  // Request operations
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Result status codes
  localparam logic [ST_W-1:0] ST_OK          = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL        = 2'd1;
  localparam logic [ST_W-1:0] ST_DOUBLE_FREE = 2'd2;
  localparam logic [ST_W-1:0] ST_RANGE       = 2'd3;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;      // latch the accepted request
    logic issue_first;  // read the first bitmap word of the request
    logic issue_next;   // read the following bitmap word of the scan
    logic commit;       // decide the result and update the bitmap
    logic out_load;     // move the pending result to the output register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic op_free;   // latched request is a free
    logic found;     // checked word holds an allocatable free block
    logic scan_end;  // checked word is the last one below the total
    logic out_busy;  // output register holds a result not yet taken
  } sts_t;

endpackage
`default_nettype wire

/* hdl/bba_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module bba_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Registered read port, holds when not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

/* hdl/bba_dp.sv */
// Datapath: bitmap memory, word scan with priority encoder, result registers.
`default_nettype none
module bba_dp (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire bba_pkg::cmd_t                   cmd,
  output bba_pkg::sts_t                        sts,
  input  wire logic                            in_op,
  input  wire logic [bba_pkg::BLK_W-1:0]       in_block_number,
  input  wire logic                            cfg_wr_en,
  input  wire logic [bba_pkg::TOTAL_W-1:0]     cfg_wr_data,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic      [bba_pkg::BLK_W-1:0]       out_result_block,
  output logic      [bba_pkg::ST_W-1:0]        out_status
);

  localparam int BIT_W = bba_pkg::BIT_W;
  localparam logic [bba_pkg::WORD_BITS-1:0] ONE_HOT0 =
    {{(bba_pkg::WORD_BITS-1){1'b0}}, 1'b1};

  logic                              op_r;
  logic [bba_pkg::BLK_W-1:0]         blk_r;
  logic [bba_pkg::TOTAL_W-1:0]       total_r;
  logic [bba_pkg::TOTAL_W-1:0]       eff_total;
  logic [bba_pkg::NUM_WORDS-1:0]     row_vld_r;
  logic                              rd_vld_r;
  logic [bba_pkg::WADDR_W-1:0]       chk_addr_r;
  logic [bba_pkg::WADDR_W-1:0]       rd_addr;
  logic                              rd_en;
  logic [bba_pkg::WORD_BITS-1:0]     ram_dout;
  logic [bba_pkg::WORD_BITS-1:0]     word_cur;
  logic [bba_pkg::WORD_BITS-1:0]     allow;
  logic [bba_pkg::WORD_BITS-1:0]     free_bits;
  logic [bba_pkg::BIT_W-1:0]         enc_idx;
  logic                              found;
  logic [bba_pkg::TOTAL_W-BIT_W-1:0] total_hi;
  logic [bba_pkg::BIT_W-1:0]         total_lo;
  logic [bba_pkg::TOTAL_W-BIT_W-1:0] chk_ext;
  logic                              word_full;
  logic                              word_part;
  logic                              scan_end;
  logic [bba_pkg::BIT_W-1:0]         blk_lo;
  logic                              in_range;
  logic                              wr_ok;
  logic [bba_pkg::WORD_BITS-1:0]     wr_word;
  logic [bba_pkg::BLK_W-1:0]         res;
  logic [bba_pkg::ST_W-1:0]          st;
  logic [bba_pkg::BLK_W-1:0]         pend_res_r;
  logic [bba_pkg::ST_W-1:0]          pend_st_r;
  logic                              out_valid_r;
  logic [bba_pkg::BLK_W-1:0]         out_res_r;
  logic [bba_pkg::ST_W-1:0]          out_st_r;

  // Hold the configured total; saturate it to the bitmap size
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= bba_pkg::TOTAL_RESET;
    end else if (cfg_wr_en) begin
      total_r <= cfg_wr_data;
    end
  end
  assign eff_total = (total_r > bba_pkg::TOTAL_RESET) ? bba_pkg::TOTAL_RESET : total_r;

  // Latch the accepted request
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r  <= in_op;
      blk_r <= in_block_number;
    end
  end

  // Read address: word of the freed block or word zero, then step by one
  always_comb begin
    rd_en = cmd.issue_first | cmd.issue_next;
    if (cmd.issue_first) begin
      rd_addr = (op_r == bba_pkg::OP_FREE) ? blk_r[bba_pkg::BLK_W-1:BIT_W] : '0;
    end else begin
      rd_addr = chk_addr_r + bba_pkg::WADDR_W'(1);
    end
  end

  // Track the address and the row valid bit of the word in flight
  always_ff @(posedge clk) begin
    if (rd_en) begin
      chk_addr_r <= rd_addr;
      rd_vld_r   <= row_vld_r[rd_addr];
    end
  end

  bba_ram #(
    .WIDTH (bba_pkg::WORD_BITS),
    .DEPTH (bba_pkg::NUM_WORDS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_ok),
    .wr_addr (chk_addr_r),
    .wr_data (wr_word),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (ram_dout)
  );

  // A row never written since reset reads as all free
  assign word_cur = rd_vld_r ? ram_dout : '0;

  // Mask off blocks at or above the total
  assign total_hi  = eff_total[bba_pkg::TOTAL_W-1:BIT_W];
  assign total_lo  = eff_total[BIT_W-1:0];
  assign chk_ext   = {1'b0, chk_addr_r};
  assign word_full = total_hi > chk_ext;
  assign word_part = total_hi == chk_ext;
  always_comb begin
    for (int b = 0; b < bba_pkg::WORD_BITS; b++) begin
      allow[b] = word_full | (word_part & (BIT_W'(b) < total_lo));
    end
  end
  assign free_bits = ~word_cur & allow;
  assign found     = |free_bits;

  // Priority encode the lowest free block
  always_comb begin
    enc_idx = '0;
    for (int b = bba_pkg::WORD_BITS - 1; b >= 0; b--) begin
      if (free_bits[b]) begin
        enc_idx = BIT_W'(b);
      end
    end
  end

  // Stop the scan once the next word starts at or above the total
  assign scan_end = {chk_ext + 1'b1, {BIT_W{1'b0}}} >= eff_total;

  // Decide the result and the bitmap update
  assign blk_lo   = blk_r[BIT_W-1:0];
  assign in_range = {1'b0, blk_r} < eff_total;
  always_comb begin
    res     = '0;
    st      = bba_pkg::ST_FULL;
    wr_ok   = 1'b0;
    wr_word = word_cur;
    if (op_r == bba_pkg::OP_FREE) begin
      res = blk_r;
      if (!in_range) begin
        st = bba_pkg::ST_RANGE;
      end else if (!word_cur[blk_lo]) begin
        st = bba_pkg::ST_DOUBLE_FREE;
      end else begin
        st      = bba_pkg::ST_OK;
        wr_ok   = cmd.commit;
        wr_word = word_cur & ~(ONE_HOT0 << blk_lo);
      end
    end else if (found) begin
      res     = {chk_addr_r, enc_idx};
      st      = bba_pkg::ST_OK;
      wr_ok   = cmd.commit;
      wr_word = word_cur | (ONE_HOT0 << enc_idx);
    end
  end

  // Mark a row valid once written
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
    end else if (wr_ok) begin
      row_vld_r[chk_addr_r] <= 1'b1;
    end
  end

  // Hold the result until the output register frees up
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      pend_res_r <= res;
      pend_st_r  <= st;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_res_r <= pend_res_r;
      out_st_r  <= pend_st_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_block = out_res_r;
  assign out_status       = out_st_r;

  assign sts.op_free  = op_r == bba_pkg::OP_FREE;
  assign sts.found    = found;
  assign sts.scan_end = scan_end;
  assign sts.out_busy = out_valid_r & ~out_ready;

endmodule
`default_nettype wire

/* hdl/bba_ctrl.sv */
// Controller: sequences request capture, bitmap reads, commit and output.
`default_nettype none
module bba_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire bba_pkg::sts_t sts,
  output bba_pkg::cmd_t      cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ISSUE = 3'd1;
  localparam logic [2:0] S_CHK   = 3'd2;
  localparam logic [2:0] S_DONE  = 3'd3;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        if (in_valid) begin
          state_nxt = S_ISSUE;
        end
      end
      S_ISSUE: begin
        cmd.issue_first = 1'b1;
        state_nxt       = S_CHK;
      end
      S_CHK: begin
        if (sts.op_free || sts.found || sts.scan_end) begin
          cmd.commit = 1'b1;
          state_nxt  = S_DONE;
        end else begin
          cmd.issue_next = 1'b1;
        end
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Advance state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

/* hdl/bitmap_block_allocator.sv */
// Top level of the first-fit bitmap block allocator.
//
//   channel  direction  handshake             payload
//   in_      request    in_valid/in_ready     in_op, in_block_number
//   out_     result     out_valid/out_ready   out_result_block, out_status
//   cfg_     register   cfg_wr_en             cfg_wr_data (total_blocks)
//
// A free request passes the issue, check and done states before its result is loaded.
// An allocate request scans 1 to 64 bitmap words in the check state, one at a time through
// the one-word-per-cycle read port of the bitmap memory; the next request waits for idle.
// Synchronous reset marks every bitmap row as all free at once; no clear pass.
// A new request is taken while a result waits in the output register; a
// finished result then waits internally until the output register is free.
`default_nettype none
module bitmap_block_allocator (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic                        in_op,
  input  wire logic [bba_pkg::BLK_W-1:0]   in_block_number,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic      [bba_pkg::BLK_W-1:0]   out_result_block,
  output logic      [bba_pkg::ST_W-1:0]    out_status,
  input  wire logic                        cfg_wr_en,
  input  wire logic [bba_pkg::TOTAL_W-1:0] cfg_wr_data
);

  bba_pkg::cmd_t cmd;
  bba_pkg::sts_t sts;

  bba_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bba_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_op            (in_op),
    .in_block_number  (in_block_number),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_block (out_result_block),
    .out_status       (out_status)
  );

  // A request in progress blocks the next one
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while another is in progress");

  // Commit and scan step never coincide
  a_commit_no_step: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.commit && (cmd.issue_next || cmd.issue_first)))
    else $error("bitmap read issued in the commit cycle");

  // A full result carries block zero
  a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == bba_pkg::ST_FULL |-> out_result_block == '0)
    else $error("full status with nonzero block");

  // No capture right after a commit
  a_load_after_commit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> !cmd.capture)
    else $error("request captured right after commit");

endmodule
`default_nettype wire
